// ===== rtl/bffa_pkg.sv =====
`timescale 1ns / 1ps

package bffa_pkg;

    localparam int NUM_BLOCKS = 1024;
    localparam int MAX_ALLOCS = 64;

    localparam int BLK_W  = $clog2(NUM_BLOCKS);   // block address
    localparam int CNT_W  = BLK_W + 1;            // block count, holds NUM_BLOCKS
    localparam int TA_W   = (MAX_ALLOCS > 1) ? $clog2(MAX_ALLOCS) : 1;
    localparam int BYTE_W = 24;
    localparam int ID_W   = 16;
    localparam int SHF_W  = 4;
    localparam int CFG_W  = 11;
    localparam int CIDX_W = 1;

    localparam logic [CIDX_W-1:0] CFG_BLOCK_SHIFT   = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_BLOCKS_IN_USE = 1'b1;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NO_SPACE     = 3'd1,
        ST_ZERO_SIZE    = 3'd2,
        ST_TABLE_FULL   = 3'd3,
        ST_ID_UNKNOWN   = 3'd4,
        ST_ID_DUPLICATE = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_TSCAN,
        S_BSCAN,
        S_MARK,
        S_FREE
    } t_state;

    typedef struct packed {
        t_cmd              command;
        logic [BYTE_W-1:0] byte_count;
        logic [ID_W-1:0]   alloc_id;
    } t_req;

    typedef struct packed {
        t_status          status;
        logic [BLK_W-1:0] start_block;
        logic [CNT_W-1:0] block_count;
    } t_rsp;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [BLK_W-1:0] start;
        logic [CNT_W-1:0] length;
    } t_entry;

endpackage

// ===== rtl/bitmap_first_fit_allocator.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Ports                             Handshake
// command   in         start, busy, i_req                beat taken when start && !busy
// result    out        o_done, o_rsp                     one-cycle strobe, no back-pressure
// config    in         i_cfg_we, i_cfg_idx, i_cfg_data   written on any edge with i_cfg_we
//
// A zero-size allocate answers in the next cycle. Every other command first walks the
// 64-entry allocation table through its single read port. An allocate then walks the
// block bitmap, one bit per cycle, and marks the found run one block per cycle. A free
// clears its run one block per cycle. The bitmap's single write port sets these rates.
// Reset: after i_rst_n the bitmap is cleared in one pass over all NUM_BLOCKS blocks with
// busy high; configuration writes are taken during it. The receiver cannot stall the
// result beat.

module bitmap_first_fit_allocator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  bffa_pkg::t_req                 i_req,
    output logic                           o_done,
    output bffa_pkg::t_rsp                 o_rsp,
    input  logic                           i_cfg_we,
    input  logic [bffa_pkg::CIDX_W-1:0]    i_cfg_idx,
    input  logic [bffa_pkg::CFG_W-1:0]     i_cfg_data
);

    // configuration
    logic [bffa_pkg::SHF_W-1:0]  r_block_shift;
    logic [bffa_pkg::CNT_W-1:0]  r_blocks_in_use;

    // sequencer
    bffa_pkg::t_state            r_state, n_state;
    logic [bffa_pkg::CNT_W-1:0]  r_addr, n_addr;       // bitmap address / clear counter
    logic [bffa_pkg::CNT_W-1:0]  r_cnt, n_cnt;         // blocks left to mark or clear
    logic                        r_rd_vld, n_rd_vld;   // bitmap read in flight
    logic [bffa_pkg::BLK_W-1:0]  r_rd_idx, n_rd_idx;
    logic [bffa_pkg::CNT_W-1:0]  r_run, n_run;
    logic [bffa_pkg::BLK_W-1:0]  r_bstart, n_bstart;
    logic [bffa_pkg::CNT_W-1:0]  r_need, n_need;
    logic [bffa_pkg::CNT_W-1:0]  r_n, n_n;             // managed blocks, saturated
    logic                        r_too_big, n_too_big;
    bffa_pkg::t_cmd              r_cmd, n_cmd;
    logic [bffa_pkg::ID_W-1:0]   r_id, n_id;
    logic [bffa_pkg::TA_W:0]     r_tk, n_tk;           // table read issue counter
    logic                        r_t_vld, n_t_vld;     // table read in flight
    logic [bffa_pkg::TA_W-1:0]   r_t_idx, n_t_idx;
    logic                        r_slot_ok, n_slot_ok;
    logic [bffa_pkg::TA_W-1:0]   r_slot, n_slot;
    logic [bffa_pkg::MAX_ALLOCS-1:0] r_valid, n_valid;

    // result beat
    logic                        r_done, n_done;
    bffa_pkg::t_rsp              r_rsp, n_rsp;

    // memories
    logic                        bm_mem [bffa_pkg::NUM_BLOCKS];
    logic                        r_bm_q;
    logic                        bm_we;
    logic [bffa_pkg::BLK_W-1:0]  bm_wa;
    logic                        bm_wd;
    bffa_pkg::t_entry            tab_mem [bffa_pkg::MAX_ALLOCS];
    bffa_pkg::t_entry            r_tq;
    logic                        tab_we;
    bffa_pkg::t_entry            tab_wd;

    // helpers
    logic [bffa_pkg::BYTE_W-1:0] req_need;
    logic [bffa_pkg::CNT_W-1:0]  n_eff;
    logic                        t_hit;
    logic [bffa_pkg::BLK_W-1:0]  run_st;
    logic [bffa_pkg::CNT_W-1:0]  run_nx;

    assign busy   = (r_state != bffa_pkg::S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // configuration registers, written whenever the enable is up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_shift   <= '0;
            r_blocks_in_use <= bffa_pkg::CNT_W'(bffa_pkg::NUM_BLOCKS);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bffa_pkg::CFG_BLOCK_SHIFT:   r_block_shift   <= i_cfg_data[bffa_pkg::SHF_W-1:0];
                bffa_pkg::CFG_BLOCKS_IN_USE: r_blocks_in_use <= i_cfg_data[bffa_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // bitmap: one write port, one registered read port driven by the scan address
    always_ff @(posedge i_clk) begin
        if (bm_we) begin
            bm_mem[bm_wa] <= bm_wd;
        end
        r_bm_q <= bm_mem[r_addr[bffa_pkg::BLK_W-1:0]];
    end

    // allocation table: one write port, one registered read port driven by the issue counter
    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            tab_mem[r_slot] <= tab_wd;
        end
        r_tq <= tab_mem[r_tk[bffa_pkg::TA_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bffa_pkg::S_CLEAR;
            r_addr    <= '0;
            r_cnt     <= '0;
            r_rd_vld  <= 1'b0;
            r_run     <= '0;
            r_tk      <= '0;
            r_t_vld   <= 1'b0;
            r_slot_ok <= 1'b0;
            r_valid   <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_cnt     <= n_cnt;
            r_rd_vld  <= n_rd_vld;
            r_run     <= n_run;
            r_tk      <= n_tk;
            r_t_vld   <= n_t_vld;
            r_slot_ok <= n_slot_ok;
            r_valid   <= n_valid;
            r_done    <= n_done;
        end
        r_rd_idx  <= n_rd_idx;
        r_bstart  <= n_bstart;
        r_need    <= n_need;
        r_n       <= n_n;
        r_too_big <= n_too_big;
        r_cmd     <= n_cmd;
        r_id      <= n_id;
        r_t_idx   <= n_t_idx;
        r_slot    <= n_slot;
        r_rsp     <= n_rsp;
    end

    always_comb begin
        req_need = i_req.byte_count >> r_block_shift;
        n_eff    = (r_blocks_in_use > bffa_pkg::CNT_W'(bffa_pkg::NUM_BLOCKS))
                 ? bffa_pkg::CNT_W'(bffa_pkg::NUM_BLOCKS) : r_blocks_in_use;
        t_hit    = r_valid[r_t_idx] && (r_tq.id == r_id);
        run_st   = (r_run == '0) ? r_rd_idx : r_bstart;
        run_nx   = r_run + 1'b1;

        n_state   = r_state;
        n_addr    = r_addr;
        n_cnt     = r_cnt;
        n_rd_vld  = r_rd_vld;
        n_rd_idx  = r_rd_idx;
        n_run     = r_run;
        n_bstart  = r_bstart;
        n_need    = r_need;
        n_n       = r_n;
        n_too_big = r_too_big;
        n_cmd     = r_cmd;
        n_id      = r_id;
        n_tk      = r_tk;
        n_t_vld   = r_t_vld;
        n_t_idx   = r_t_idx;
        n_slot_ok = r_slot_ok;
        n_slot    = r_slot;
        n_valid   = r_valid;
        n_done    = 1'b0;
        n_rsp     = r_rsp;

        bm_we  = 1'b0;
        bm_wa  = r_addr[bffa_pkg::BLK_W-1:0];
        bm_wd  = 1'b0;
        tab_we = 1'b0;
        tab_wd = '{id: r_id, start: r_bstart, length: r_need};

        unique case (r_state)
            bffa_pkg::S_CLEAR: begin
                // sweep the bitmap to all free after reset
                bm_we  = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == bffa_pkg::CNT_W'(bffa_pkg::NUM_BLOCKS - 1)) begin
                    n_addr  = '0;
                    n_state = bffa_pkg::S_IDLE;
                end
            end

            bffa_pkg::S_IDLE: begin
                if (start) begin
                    n_cmd     = i_req.command;
                    n_id      = i_req.alloc_id;
                    n_need    = req_need[bffa_pkg::CNT_W-1:0];
                    n_n       = n_eff;
                    n_too_big = (req_need > bffa_pkg::BYTE_W'(n_eff));
                    if (i_req.command == bffa_pkg::CMD_ALLOC && req_need == '0) begin
                        n_done = 1'b1;
                        n_rsp  = '{status: bffa_pkg::ST_ZERO_SIZE, start_block: '0,
                                   block_count: '0};
                    end else begin
                        n_tk      = '0;
                        n_t_vld   = 1'b0;
                        n_slot_ok = 1'b0;
                        n_state   = bffa_pkg::S_TSCAN;
                    end
                end
            end

            bffa_pkg::S_TSCAN: begin
                // issue the next table read
                if (r_tk != (bffa_pkg::TA_W+1)'(bffa_pkg::MAX_ALLOCS)) begin
                    n_t_idx = r_tk[bffa_pkg::TA_W-1:0];
                    n_tk    = r_tk + 1'b1;
                    n_t_vld = 1'b1;
                end else begin
                    n_t_vld = 1'b0;
                end
                if (r_t_vld) begin
                    // check the entry read last cycle
                    if (!r_valid[r_t_idx] && !r_slot_ok) begin
                        n_slot_ok = 1'b1;
                        n_slot    = r_t_idx;
                    end
                    if (t_hit) begin
                        if (r_cmd == bffa_pkg::CMD_FREE) begin
                            n_valid[r_t_idx] = 1'b0;
                            n_bstart = r_tq.start;
                            n_need   = r_tq.length;
                            n_addr   = {1'b0, r_tq.start};
                            n_cnt    = r_tq.length;
                            n_state  = bffa_pkg::S_FREE;
                        end else begin
                            n_done  = 1'b1;
                            n_rsp   = '{status: bffa_pkg::ST_ID_DUPLICATE, start_block: '0,
                                        block_count: '0};
                            n_state = bffa_pkg::S_IDLE;
                        end
                    end
                end else if (r_tk == (bffa_pkg::TA_W+1)'(bffa_pkg::MAX_ALLOCS)) begin
                    // whole table seen, no match
                    priority if (r_cmd == bffa_pkg::CMD_FREE) begin
                        n_done  = 1'b1;
                        n_rsp   = '{status: bffa_pkg::ST_ID_UNKNOWN, start_block: '0,
                                    block_count: '0};
                        n_state = bffa_pkg::S_IDLE;
                    end else if (!r_slot_ok) begin
                        n_done  = 1'b1;
                        n_rsp   = '{status: bffa_pkg::ST_TABLE_FULL, start_block: '0,
                                    block_count: '0};
                        n_state = bffa_pkg::S_IDLE;
                    end else if (r_too_big) begin
                        n_done  = 1'b1;
                        n_rsp   = '{status: bffa_pkg::ST_NO_SPACE, start_block: '0,
                                    block_count: '0};
                        n_state = bffa_pkg::S_IDLE;
                    end else begin
                        n_addr   = '0;
                        n_rd_vld = 1'b0;
                        n_run    = '0;
                        n_state  = bffa_pkg::S_BSCAN;
                    end
                end
            end

            bffa_pkg::S_BSCAN: begin
                // issue the next bitmap read
                if (r_addr < r_n) begin
                    n_rd_idx = r_addr[bffa_pkg::BLK_W-1:0];
                    n_addr   = r_addr + 1'b1;
                    n_rd_vld = 1'b1;
                end else begin
                    n_rd_vld = 1'b0;
                end
                if (r_rd_vld) begin
                    if (r_bm_q) begin
                        n_run = '0;
                    end else if (run_nx == r_need) begin
                        n_bstart = run_st;
                        n_addr   = {1'b0, run_st};
                        n_cnt    = r_need;
                        n_rd_vld = 1'b0;
                        n_run    = '0;
                        n_state  = bffa_pkg::S_MARK;
                    end else begin
                        n_run    = run_nx;
                        n_bstart = run_st;
                    end
                end else if (r_addr >= r_n) begin
                    n_done  = 1'b1;
                    n_rsp   = '{status: bffa_pkg::ST_NO_SPACE, start_block: '0,
                                block_count: '0};
                    n_state = bffa_pkg::S_IDLE;
                end
            end

            bffa_pkg::S_MARK: begin
                // set one block per cycle; record the entry on the last one
                bm_we  = 1'b1;
                bm_wd  = 1'b1;
                n_addr = r_addr + 1'b1;
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == bffa_pkg::CNT_W'(1)) begin
                    tab_we          = 1'b1;
                    n_valid[r_slot] = 1'b1;
                    n_done          = 1'b1;
                    n_rsp           = '{status: bffa_pkg::ST_OK, start_block: r_bstart,
                                        block_count: r_need};
                    n_state         = bffa_pkg::S_IDLE;
                end
            end

            bffa_pkg::S_FREE: begin
                // release one block per cycle
                bm_we  = 1'b1;
                n_addr = r_addr + 1'b1;
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt <= bffa_pkg::CNT_W'(1)
                        || r_addr == bffa_pkg::CNT_W'(bffa_pkg::NUM_BLOCKS - 1)) begin
                    n_done  = 1'b1;
                    n_rsp   = '{status: bffa_pkg::ST_OK, start_block: r_bstart,
                                block_count: r_need};
                    n_state = bffa_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = bffa_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // a result beat is only given on the way back to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == bffa_pkg::S_IDLE))
        else $error("result beat while sequencer is working");

    // an accepted command either answers at once or holds busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted command vanished");

    // a successful beat always moves at least one block
    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status == bffa_pkg::ST_OK) |-> (o_rsp.block_count != '0))
        else $error("ok result with zero blocks");

    // errors report zero start and count
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status != bffa_pkg::ST_OK)
            |-> (o_rsp.start_block == '0 && o_rsp.block_count == '0))
        else $error("error result with nonzero fields");

    // the free-run length never reaches the request during the scan
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bffa_pkg::S_BSCAN) |-> (r_run < r_need))
        else $error("run counter passed request length");
`endif

endmodule
